// ----- hdl/ixe_pkg.sv -----
// Shared types, constants and helpers for the infix expression evaluator.
// Used by ixe_cell, ixe_mul and infix_expression_evaluator; no dependencies.
package ixe_pkg;

    // Nesting limit and the width of the depth counter (must hold MAX_DEPTH itself)
    localparam int MAX_DEPTH = 64;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

    // Token kinds
    typedef enum logic [2:0] {
        OP_NUM   = 3'd0,
        OP_PLUS  = 3'd1,
        OP_MINUS = 3'd2,
        OP_TIMES = 3'd3,
        OP_OPEN  = 3'd4,
        OP_CLOSE = 3'd5
    } t_op;

    // Completion status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DEPTH   = 2'd1,
        ST_BRACKET = 2'd2,
        ST_OPERAND = 2'd3
    } t_status;

    // Pending prefix: bit 0 negate, bit 1 times
    localparam logic [1:0] PFX_NONE  = 2'b00;
    localparam int         PFX_NEG   = 0;
    localparam int         PFX_TIMES = 1;
    localparam logic [1:0] PFX_MUL   = 2'b10;

    // One evaluation frame: finished sum, last term, term valid, pending prefix
    typedef struct packed {
        logic [63:0] sum;
        logic [63:0] last;
        logic        has;
        logic [1:0]  pfx;
    } t_frame;

    // Sticky first error: keep the earlier code if one is already set
    function automatic t_status flag_err(input t_status cur, input t_status code);
        flag_err = (cur == ST_OK) ? code : cur;
    endfunction

    // Full 32x32 unsigned product
    function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
        mul32 = {32'b0, a} * {32'b0, b};
    endfunction

endpackage

// ----- hdl/infix_expression_evaluator.sv -----
// Infix expression evaluator: one token per request, 64-bit wraparound sums.
// A token that completes a multiplication holds the input (o_stall high) while
// ixe_mul runs. Throughput: 1 token per cycle otherwise, while o_stall is low.
// A last token's result is registered in the finish cycle, after any product lands;
// that cycle takes no token and waits while i_stall holds the earlier result.
// Reset (i_rst_n low, synchronous) clears the frame, depth, errors and valids.
module infix_expression_evaluator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic signed [31:0] i_value,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [63:0] o_result,
    output logic [1:0]  o_status
);

    // Current frame and control
    logic [63:0]                 r_sum, n_sum;
    logic [63:0]                 r_last, n_last;
    logic                        r_has, n_has;
    logic [1:0]                  r_pfx, n_pfx;
    logic [ixe_pkg::DEPTH_W-1:0] r_depth, n_depth;
    ixe_pkg::t_status            r_err, n_err;
    logic                        r_fin;
    logic                        r_fin_wait;
    logic                        r_out_valid;
    logic [63:0]                 r_out_result;
    logic [1:0]                  r_out_status;

    // Stack chain
    ixe_pkg::t_frame w_entry [ixe_pkg::MAX_DEPTH];
    ixe_pkg::t_frame w_cur;
    logic            w_push;
    logic            w_pop;

    // Datapath
    logic            w_acc;
    logic            w_fin_go;
    logic            w_take;
    ixe_pkg::t_frame w_src;
    logic [63:0]     w_opnd;
    logic [63:0]     w_sext;
    logic [63:0]     w_lsel;
    logic [63:0]     w_g;
    logic [63:0]     w_g_neg;
    logic [63:0]     w_num_neg;
    logic            w_mul_start;
    logic [63:0]     w_mul_a;
    logic            w_mul_busy;
    logic            w_mul_done;
    logic [63:0]     w_product;
    ixe_pkg::t_status w_status;

    assign w_cur    = '{sum: r_sum, last: r_last, has: r_has, pfx: r_pfx};
    assign o_stall  = w_mul_busy | r_fin;
    assign w_acc    = i_valid & ~o_stall;
    assign w_fin_go = r_fin & ~(r_out_valid & i_stall);

    // Operand candidates: number and group value, plain and negated
    assign w_sext    = {{32{i_value[31]}}, i_value};
    assign w_num_neg = 64'd0 - w_sext;
    assign w_lsel    = r_has ? r_last : 64'd0;
    assign w_g       = r_sum + w_lsel;
    assign w_g_neg   = (~r_sum) + (~w_lsel) + 64'd2;

    // Status at end of expression
    always_comb begin
        if (r_err != ixe_pkg::ST_OK) begin
            w_status = r_err;
        end else if (r_depth != '0) begin
            w_status = ixe_pkg::ST_BRACKET;
        end else if (!r_has || r_pfx != ixe_pkg::PFX_NONE) begin
            w_status = ixe_pkg::ST_OPERAND;
        end else begin
            w_status = ixe_pkg::ST_OK;
        end
    end

    // Token decode and frame update
    always_comb begin
        n_sum       = r_sum;
        n_last      = r_last;
        n_has       = r_has;
        n_pfx       = r_pfx;
        n_depth     = r_depth;
        n_err       = r_err;
        w_push      = 1'b0;
        w_pop       = 1'b0;
        w_take      = 1'b0;
        w_src       = w_cur;
        w_opnd      = w_sext;
        w_mul_start = 1'b0;
        w_mul_a     = r_last;

        if (w_mul_done) begin
            n_last = w_product;
        end

        if (w_fin_go) begin
            n_sum   = '0;
            n_last  = '0;
            n_has   = 1'b0;
            n_pfx   = ixe_pkg::PFX_NONE;
            n_depth = '0;
            n_err   = ixe_pkg::ST_OK;
        end else if (w_acc) begin
            unique case (ixe_pkg::t_op'(i_op))
                ixe_pkg::OP_NUM: begin
                    w_take = 1'b1;
                    w_src  = w_cur;
                    w_opnd = r_pfx[ixe_pkg::PFX_NEG] ? w_num_neg : w_sext;
                end
                ixe_pkg::OP_PLUS: begin
                    if (r_pfx != ixe_pkg::PFX_NONE) begin
                        n_err = ixe_pkg::flag_err(r_err, ixe_pkg::ST_OPERAND);
                        n_pfx = ixe_pkg::PFX_NONE;
                    end
                end
                ixe_pkg::OP_MINUS: begin
                    n_pfx[ixe_pkg::PFX_NEG] = ~r_pfx[ixe_pkg::PFX_NEG];
                end
                ixe_pkg::OP_TIMES: begin
                    if (r_pfx != ixe_pkg::PFX_NONE || !r_has) begin
                        n_err = ixe_pkg::flag_err(r_err, ixe_pkg::ST_OPERAND);
                    end
                    n_pfx = ixe_pkg::PFX_MUL;
                end
                ixe_pkg::OP_OPEN: begin
                    if (r_depth == ixe_pkg::DEPTH_W'(ixe_pkg::MAX_DEPTH)) begin
                        n_err = ixe_pkg::flag_err(r_err, ixe_pkg::ST_DEPTH);
                    end else begin
                        w_push  = 1'b1;
                        n_depth = r_depth + 1'b1;
                        n_sum   = '0;
                        n_last  = '0;
                        n_has   = 1'b0;
                        n_pfx   = ixe_pkg::PFX_NONE;
                    end
                end
                ixe_pkg::OP_CLOSE: begin
                    if (r_depth == '0) begin
                        n_err = ixe_pkg::flag_err(r_err, ixe_pkg::ST_BRACKET);
                    end else begin
                        if (!r_has || r_pfx != ixe_pkg::PFX_NONE) begin
                            n_err = ixe_pkg::flag_err(r_err, ixe_pkg::ST_OPERAND);
                        end
                        w_pop   = 1'b1;
                        n_depth = r_depth - 1'b1;
                        w_take  = 1'b1;
                        w_src   = w_entry[0];
                        w_opnd  = w_entry[0].pfx[ixe_pkg::PFX_NEG] ? w_g_neg : w_g;
                    end
                end
                default: begin
                end
            endcase

            // Fold the operand into the source frame
            if (w_take) begin
                n_has = 1'b1;
                n_pfx = ixe_pkg::PFX_NONE;
                if (w_src.pfx[ixe_pkg::PFX_TIMES]) begin
                    n_sum = w_src.sum;
                    if (w_src.has) begin
                        w_mul_start = 1'b1;
                        w_mul_a     = w_src.last;
                        n_last      = w_src.last;
                    end else begin
                        n_err  = ixe_pkg::flag_err(n_err, ixe_pkg::ST_OPERAND);
                        n_last = w_opnd;
                    end
                end else begin
                    n_sum  = w_src.sum + (w_src.has ? w_src.last : 64'd0);
                    n_last = w_opnd;
                end
            end
        end
    end

    // Frame and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_last      <= '0;
            r_has       <= 1'b0;
            r_pfx       <= ixe_pkg::PFX_NONE;
            r_depth     <= '0;
            r_err       <= ixe_pkg::ST_OK;
            r_fin       <= 1'b0;
            r_fin_wait  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum   <= n_sum;
            r_last  <= n_last;
            r_has   <= n_has;
            r_pfx   <= n_pfx;
            r_depth <= n_depth;
            r_err   <= n_err;

            // Finish request once any pending product has landed
            if (w_acc && i_last && !w_mul_start) begin
                r_fin <= 1'b1;
            end else if (w_mul_done && r_fin_wait) begin
                r_fin <= 1'b1;
            end else if (w_fin_go) begin
                r_fin <= 1'b0;
            end

            if (w_acc && i_last && w_mul_start) begin
                r_fin_wait <= 1'b1;
            end else if (w_mul_done) begin
                r_fin_wait <= 1'b0;
            end

            // Output register
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            r_out_result <= w_g;
            r_out_status <= w_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out_result;
    assign o_status = r_out_status;

    // Frame stack: cell 0 holds the innermost saved frame
    for (genvar k = 0; k < ixe_pkg::MAX_DEPTH; k++) begin : g_cell
        ixe_cell u_cell (
            .i_clk       (i_clk),
            .i_push      (w_push),
            .i_pop       (w_pop),
            .i_from_up   ((k == 0) ? w_cur : w_entry[(k == 0) ? 0 : k - 1]),
            .i_from_down (w_entry[(k == ixe_pkg::MAX_DEPTH - 1) ? k : k + 1]),
            .o_entry     (w_entry[k])
        );
    end

    // Multiplier for terms joined by times
    ixe_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_opnd),
        .o_busy    (w_mul_busy),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

endmodule

// ----- hdl/ixe_cell.sv -----
// One cell of the frame stack chain: holds a saved frame and shifts with
// its neighbors on push and pop. Depends on ixe_pkg.
module ixe_cell (
    input  logic            i_clk,
    input  logic            i_push,
    input  logic            i_pop,
    input  ixe_pkg::t_frame i_from_up,
    input  ixe_pkg::t_frame i_from_down,
    output ixe_pkg::t_frame o_entry
);

    ixe_pkg::t_frame r_entry;

    // Shift toward the bottom on push, toward the top on pop
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry <= i_from_up;
        end else if (i_pop) begin
            r_entry <= i_from_down;
        end
    end

    assign o_entry = r_entry;

endmodule

// ----- hdl/ixe_mul.sv -----
// 64x64 wraparound multiplier built from three 32x32 products; the operands and
// then the partial products are registered. Depends on ixe_pkg.
module ixe_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_product
);

    logic [63:0] r_a;
    logic [63:0] r_b;
    logic        r_v0;
    logic        r_v1;
    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] w_lh;
    logic [63:0] w_hl;
    logic [31:0] w_cross;

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= i_start;
            r_v1 <= r_v0;
        end
    end

    // Operand capture, then partial products (only low 64 bits matter)
    assign w_lh = ixe_pkg::mul32(r_a[31:0], r_b[63:32]);
    assign w_hl = ixe_pkg::mul32(r_a[63:32], r_b[31:0]);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        r_ll <= ixe_pkg::mul32(r_a[31:0], r_b[31:0]);
        r_lh <= w_lh[31:0];
        r_hl <= w_hl[31:0];
    end

    // Recombine
    assign w_cross   = r_lh + r_hl;
    assign o_product = r_ll + {w_cross, 32'b0};
    assign o_busy    = r_v0 | r_v1;
    assign o_done    = r_v1;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for infix_expression_evaluator: directed token table, then random
// expressions, each checked against a predictor. Depends on ixe_pkg and the evaluator RTL.
module tb;
    import ixe_pkg::*;

    // Token kinds that the evaluator ignores
    localparam logic [2:0] OP_RSV_A = 3'd6;
    localparam logic [2:0] OP_RSV_B = 3'd7;

    localparam int RANDOM_TOKENS = 1600;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AT       = 25;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] val;
        bit          is_last;
    } t_token;

    typedef struct {
        logic [63:0] total;
        t_status     st;
    } t_total;

    // One row: token, repeat count (last only on the final copy), optional typed-in result
    typedef struct {
        logic [2:0]  op;
        logic [31:0] val;
        bit          is_last;
        int          reps;
        bit          typed;
        logic [63:0] want;
        t_status     want_st;
    } t_script_row;

    localparam int SCRIPT_LEN = 41;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_op = OP_NUM;
    logic signed [31:0] i_value = '0;
    logic               i_last = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [63:0] o_result;
    logic [1:0]         o_status;

    wire req_taken = i_valid && !o_stall;
    wire rsp_taken = o_valid && !i_stall;

    infix_expression_evaluator uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_op     (i_op),
        .i_value  (i_value),
        .i_last   (i_last),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result),
        .o_status (o_status)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: current frame, nesting, sticky error, saved frames
    logic [63:0] ev_sum;
    logic [63:0] ev_term;
    logic        ev_has;
    logic [1:0]  ev_pfx;
    int          ev_depth;
    t_status     ev_err;
    t_frame      saved_frames [MAX_DEPTH];

    t_total pending_totals [$];
    int     fail_cnt = 0;
    int     tokens_sent = 0;
    bit     src_calm = 1'b0;
    bit     sink_calm = 1'b0;
    bit     flood = 1'b0;

    t_script_row script [SCRIPT_LEN] = '{
        // extremes straight after reset
        '{OP_NUM,   32'h7FFF_FFFF, 1'b1, 1,  1'b1, 64'h0000_0000_7FFF_FFFF, ST_OK},
        '{OP_NUM,   32'h8000_0000, 1'b1, 1,  1'b1, 64'hFFFF_FFFF_8000_0000, ST_OK},
        // empty expression closed by an ignored token
        '{OP_RSV_A, 32'h0,         1'b1, 1,  1'b1, 64'h0, ST_OPERAND},
        '{OP_RSV_B, 32'hFFFF_FFFF, 1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_NUM,   32'hFFFF_FFFF, 1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_MINUS, 32'h0,         1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_NUM,   32'h8000_0000, 1'b1, 1,  1'b0, 64'h0, ST_OK},
        // adjacent numbers add up
        '{OP_NUM,   32'd3,         1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_NUM,   32'd4,         1'b1, 1,  1'b0, 64'h0, ST_OK},
        // repeated minus toggles the sign
        '{OP_MINUS, 32'h0,         1'b0, 2,  1'b0, 64'h0, ST_OK},
        '{OP_NUM,   32'd9,         1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_TIMES, 32'h0,         1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_MINUS, 32'h0,         1'b0, 3,  1'b0, 64'h0, ST_OK},
        '{OP_NUM,   32'd5,         1'b1, 1,  1'b0, 64'h0, ST_OK},
        // times with nothing on its left
        '{OP_TIMES, 32'h0,         1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_NUM,   32'd6,         1'b1, 1,  1'b1, 64'd6, ST_OPERAND},
        // times after a pending minus
        '{OP_NUM,   32'd2,         1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_MINUS, 32'h0,         1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_TIMES, 32'h0,         1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_NUM,   32'd3,         1'b1, 1,  1'b0, 64'h0, ST_OK},
        // plus after a pending minus
        '{OP_MINUS, 32'h0,         1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_PLUS,  32'h0,         1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_NUM,   32'd2,         1'b1, 1,  1'b0, 64'h0, ST_OK},
        // close with nothing open, then an empty group
        '{OP_CLOSE, 32'h0,         1'b1, 1,  1'b1, 64'h0, ST_BRACKET},
        '{OP_OPEN,  32'h0,         1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_CLOSE, 32'h0,         1'b1, 1,  1'b1, 64'h0, ST_OPERAND},
        // one open too many
        '{OP_OPEN,  32'h0,         1'b0, MAX_DEPTH + 1, 1'b0, 64'h0, ST_OK},
        '{OP_NUM,   32'd1,         1'b1, 1,  1'b1, 64'd1, ST_DEPTH},
        // full nesting depth, all closed
        '{OP_OPEN,  32'h0,         1'b0, MAX_DEPTH, 1'b0, 64'h0, ST_OK},
        '{OP_NUM,   32'hFFFF_FFFF, 1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_CLOSE, 32'h0,         1'b1, MAX_DEPTH, 1'b0, 64'h0, ST_OK},
        // wraparound products across a group
        '{OP_NUM,   32'h7FFF_FFFF, 1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_TIMES, 32'h0,         1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_OPEN,  32'h0,         1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_NUM,   32'h8000_0000, 1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_TIMES, 32'h0,         1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_NUM,   32'h8000_0000, 1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_CLOSE, 32'h0,         1'b1, 1,  1'b0, 64'h0, ST_OK},
        // group left open, then a trailing minus
        '{OP_OPEN,  32'h0,         1'b0, 1,  1'b0, 64'h0, ST_OK},
        '{OP_NUM,   32'd1,         1'b1, 1,  1'b1, 64'd1, ST_BRACKET},
        '{OP_MINUS, 32'h0,         1'b1, 1,  1'b0, 64'h0, ST_OK}
    };

    // Sticky first error
    function automatic void note_error(input t_status code);
        if (ev_err == ST_OK)
            ev_err = code;
    endfunction

    function automatic void clear_frame();
        ev_sum  = '0;
        ev_term = '0;
        ev_has  = 1'b0;
        ev_pfx  = PFX_NONE;
    endfunction

    // Apply the pending prefix to an operand and fold it into the frame
    function automatic void fold_operand(input logic [63:0] v);
        if (ev_pfx[PFX_NEG])
            v = -v;
        if (ev_pfx[PFX_TIMES]) begin
            if (ev_has) begin
                ev_term = ev_term * v;
            end else begin
                note_error(ST_OPERAND);
                ev_term = v;
                ev_has  = 1'b1;
            end
        end else begin
            if (ev_has)
                ev_sum = ev_sum + ev_term;
            ev_term = v;
            ev_has  = 1'b1;
        end
        ev_pfx = PFX_NONE;
    endfunction

    // Advance the predictor by one token; fire is set when the token closes an expression
    function automatic void eval_token(input t_token tk, output bit fire,
                                       output logic [63:0] total, output t_status st);
        logic [63:0] grp;
        case (tk.op)
            OP_NUM: begin
                fold_operand({{32{tk.val[31]}}, tk.val});
            end
            OP_PLUS: begin
                if (ev_pfx != PFX_NONE) begin
                    note_error(ST_OPERAND);
                    ev_pfx = PFX_NONE;
                end
            end
            OP_MINUS: begin
                ev_pfx[PFX_NEG] = ~ev_pfx[PFX_NEG];
            end
            OP_TIMES: begin
                if (ev_pfx != PFX_NONE || !ev_has)
                    note_error(ST_OPERAND);
                ev_pfx = PFX_MUL;
            end
            OP_OPEN: begin
                if (ev_depth >= MAX_DEPTH) begin
                    note_error(ST_DEPTH);
                end else begin
                    saved_frames[ev_depth] = '{sum: ev_sum, last: ev_term, has: ev_has,
                                               pfx: ev_pfx};
                    ev_depth++;
                    clear_frame();
                end
            end
            OP_CLOSE: begin
                if (ev_depth == 0) begin
                    note_error(ST_BRACKET);
                end else begin
                    if (!ev_has || ev_pfx != PFX_NONE)
                        note_error(ST_OPERAND);
                    grp = ev_sum + (ev_has ? ev_term : 64'd0);
                    ev_depth--;
                    ev_sum  = saved_frames[ev_depth].sum;
                    ev_term = saved_frames[ev_depth].last;
                    ev_has  = saved_frames[ev_depth].has;
                    ev_pfx  = saved_frames[ev_depth].pfx;
                    fold_operand(grp);
                end
            end
            default: ;
        endcase

        fire  = tk.is_last;
        total = ev_sum + (ev_has ? ev_term : 64'd0);
        st    = ev_err;
        if (st == ST_OK) begin
            if (ev_depth != 0)
                st = ST_BRACKET;
            else if (!ev_has || ev_pfx != PFX_NONE)
                st = ST_OPERAND;
        end
        if (tk.is_last) begin
            clear_frame();
            ev_depth = 0;
            ev_err   = ST_OK;
        end
    endfunction

    // Number mix: extremes, small values, full range
    function automatic logic [31:0] rand_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h0;
                endcase
            end
            1, 2: v = $urandom_range(0, 32) - 16;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic void push_tok(ref t_token q[$], input logic [2:0] op,
                                     input logic [31:0] v);
        t_token tk;
        tk.op = op;
        tk.val = v;
        tk.is_last = 1'b0;
        q = {q, tk};
    endfunction

    // Well-formed sum of terms with random operators, signs and nested groups
    function automatic void build_sum(ref t_token q[$], input int lvl);
        int terms;
        terms = $urandom_range(1, 4);
        for (int t = 0; t < terms; t++) begin
            if (t > 0) begin
                case ($urandom_range(0, 3))
                    0, 1: push_tok(q, OP_PLUS, $urandom());
                    2: push_tok(q, OP_MINUS, $urandom());
                    default: push_tok(q, OP_TIMES, $urandom());
                endcase
            end
            if ($urandom_range(0, 4) == 0)
                push_tok(q, OP_MINUS, $urandom());
            if (lvl < 5 && $urandom_range(0, 3) == 0) begin
                push_tok(q, OP_OPEN, $urandom());
                build_sum(q, lvl + 1);
                push_tok(q, OP_CLOSE, $urandom());
            end else begin
                push_tok(q, OP_NUM, rand_value());
            end
        end
    endfunction

    // Offer one request after a random gap; run the predictor when it is taken
    task automatic send_token(input t_token tk, input bit typed, input logic [63:0] want,
                              input t_status want_st);
        int gap;
        bit fire;
        logic [63:0] total;
        t_status st;
        t_total ent;
        if (tokens_sent % 16 == 0)
            src_calm = ($urandom_range(0, 3) == 0);
        gap = (src_calm || flood) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= tk.op;
        i_value <= tk.val;
        i_last  <= tk.is_last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        eval_token(tk, fire, total, st);
        if (fire) begin
            if (typed) begin
                ent.total = want;
                ent.st    = want_st;
            end else begin
                ent.total = total;
                ent.st    = st;
            end
            pending_totals = {pending_totals, ent};
        end
        tokens_sent++;
    endtask

    // Stimulus: reset, directed table, random expressions, drain
    initial begin : stim
        t_token tk;
        t_token expr [$];
        int pick;
        int n_open;
        int idx;
        clear_frame();
        ev_depth = 0;
        ev_err   = ST_OK;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[r]) begin
            for (int k = 0; k < script[r].reps; k++) begin
                tk.op      = script[r].op;
                tk.val     = script[r].val;
                tk.is_last = script[r].is_last && (k == script[r].reps - 1);
                send_token(tk, script[r].typed, script[r].want, script[r].want_st);
            end
        end

        while (tokens_sent < RANDOM_TOKENS) begin
            expr.delete();
            pick = $urandom_range(0, 39);
            if (pick == 0) begin
                // deep chain around the nesting limit, closes may not match
                n_open = $urandom_range(MAX_DEPTH - 4, MAX_DEPTH + 2);
                repeat (n_open) push_tok(expr, OP_OPEN, $urandom());
                push_tok(expr, OP_NUM, rand_value());
                repeat ($urandom_range(n_open - 2, n_open + 1))
                    push_tok(expr, OP_CLOSE, $urandom());
            end else if (pick < 5) begin
                // noise: any token kind, stray ends
                repeat ($urandom_range(1, 12)) begin
                    push_tok(expr, 3'($urandom_range(0, 7)), rand_value());
                    expr[$].is_last = ($urandom_range(0, 5) == 0);
                end
            end else begin
                build_sum(expr, 0);
                // broken sequence: one token swapped for any kind
                if (pick < 9) begin
                    idx = $urandom_range(0, expr.size() - 1);
                    expr[idx].op = 3'($urandom_range(0, 7));
                end
            end
            expr[$].is_last = 1'b1;
            foreach (expr[j])
                send_token(expr[j], 1'b0, 64'h0, ST_OK);
        end
        i_valid <= 1'b0;

        while (pending_totals.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result side: random stalls, one long hold-off, compare with the oldest expected total
    initial begin : sink
        int gap;
        int results_seen;
        t_total exp_t;
        results_seen = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (results_seen % 16 == 0)
                sink_calm = ($urandom_range(0, 3) == 0);
            gap = sink_calm ? 0 : $urandom_range(0, 17);
            if (results_seen == HOLD_AT) begin
                i_stall <= 1'b1;
                flood = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                flood = 1'b0;
            end else if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (pending_totals.size() == 0) begin
                $error("result with no expression pending: result=%0d status=%0d",
                       o_result, o_status);
                fail_cnt++;
            end else begin
                exp_t = pending_totals.pop_front();
                if (o_result !== exp_t.total) begin
                    $error("result: expected %0d, actual %0d", $signed(exp_t.total), o_result);
                    fail_cnt++;
                end
                if (o_status !== exp_t.st) begin
                    $error("status: expected %0d, actual %0d", exp_t.st, o_status);
                    fail_cnt++;
                end
            end
            results_seen++;
        end
    end

    // Watchdog: too long with neither side moving
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (req_taken || rsp_taken)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $error("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule

// ----- filelist.f -----
hdl/ixe_pkg.sv
hdl/ixe_cell.sv
hdl/ixe_mul.sv
hdl/infix_expression_evaluator.sv
sim/tb.sv
